FILE: rtl/core/tsn_pkg.sv
// Shared types, constants and threshold tables for the texel swizzle and
// normal renormalize pipeline. Depends on nothing; used by every module but tsn_checker.
`default_nettype none
package tsn_pkg;

   typedef enum logic [1:0] {
      MODE_RGB_OPAQUE = 2'd0,
      MODE_RGBA_SWAP  = 2'd1,
      MODE_NORMAL_AG  = 2'd2,
      MODE_NORMAL_RG  = 2'd3
   } mode_type;

   localparam mode_type ModeReset = MODE_RGBA_SWAP;

   localparam logic [63:0] EncScaleQ24 = 64'd2147475259;
   localparam logic [63:0] OneQ24      = 64'd16777216;
   localparam logic [48:0] ThrNever    = 49'h1_0000_0000_0001;
   localparam int          SearchSteps = 8;
   localparam logic [7:0]  ByteMid     = 8'd127;

   typedef logic [48:0] thr_sq_type;
   typedef thr_sq_type [255:0] thr_table_type;

   typedef struct packed {
      mode_type    mode;
      logic [7:0]  r;
      logic [7:0]  g;
      logic [7:0]  b;
      logic [7:0]  a;
      logic        sign_x;
      logic        sign_y;
      logic [15:0] csq_x;
      logic [15:0] csq_y;
      logic [17:0] len_sq;
      logic [7:0]  cnt_x;
      logic [7:0]  cnt_y;
   } item_type;

   // Entry j holds the squared Q24 magnitude at which the encoded byte moves
   // j steps away from the midpoint, for positive or negative components.
   function automatic thr_table_type build_thr(input logic neg);
      thr_table_type t;
      logic [63:0]   tb;
      logic [63:0]   thr;
      logic [63:0]   sq;
      int            b;
      for (int j = 0; j < 256; j++) begin
         if (j == 0) begin
            t[j] = '0;
         end else if ((!neg && j <= 128) || (neg && j <= 127)) begin
            b   = neg ? (128 - j) : (127 + j);
            tb  = ((64'(b) << 48) + EncScaleQ24 - 64'd1) / EncScaleQ24;
            thr = neg ? (OneQ24 - tb + 64'd1) : (tb - OneQ24);
            sq  = thr * thr;
            t[j] = sq[48:0];
         end else begin
            t[j] = ThrNever;
         end
      end
      return t;
   endfunction

   localparam thr_table_type ThrPos = build_thr(1'b0);
   localparam thr_table_type ThrNeg = build_thr(1'b1);

endpackage
`default_nettype wire

FILE: rtl/core/tsn_front.sv
// Entry stage: registers the request and forms component squares and the
// squared length. Depends on tsn_pkg.
`default_nettype none
module tsn_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire logic             in_valid,
   input  wire tsn_pkg::mode_type mode,
   input  wire logic [7:0]       in_b,
   input  wire logic [7:0]       in_g,
   input  wire logic [7:0]       in_r,
   input  wire logic [7:0]       in_a,
   output tsn_pkg::item_type     item_ff,
   output logic                  valid_ff
);
   tsn_pkg::item_type item_in;
   logic [7:0] mag_x, mag_y, mag_z;
   logic [15:0] csq_z;

   always_comb begin
      mag_x = in_r[7] ? 8'((in_r << 1) - 9'd255) : 8'(9'd255 - (in_r << 1));
      mag_y = in_g[7] ? 8'((in_g << 1) - 9'd255) : 8'(9'd255 - (in_g << 1));
      mag_z = in_b[7] ? 8'((in_b << 1) - 9'd255) : 8'(9'd255 - (in_b << 1));
      csq_z = mag_z * mag_z;
      item_in.mode   = mode;
      item_in.r      = in_r;
      item_in.g      = in_g;
      item_in.b      = in_b;
      item_in.a      = in_a;
      item_in.sign_x = ~in_r[7];
      item_in.sign_y = ~in_g[7];
      item_in.csq_x  = mag_x * mag_x;
      item_in.csq_y  = mag_y * mag_y;
      item_in.len_sq = 18'(item_in.csq_x) + 18'(item_in.csq_y) + 18'(csq_z);
      item_in.cnt_x  = '0;
      item_in.cnt_y  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= item_in;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/core/tsn_search_step.sv
// One binary search step on the encoded byte of both normal components.
// Depends on tsn_pkg threshold tables.
`default_nettype none
module tsn_search_step (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic [2:0]        bit_idx,
   input  wire logic              in_valid,
   input  wire tsn_pkg::item_type item,
   output tsn_pkg::item_type      item_ff,
   output logic                   valid_ff
);
   tsn_pkg::item_type item_in;
   logic [7:0]  cand_x, cand_y;
   logic [48:0] thr_x, thr_y;
   logic [66:0] rhs_x, rhs_y;
   logic [66:0] lhs_x, lhs_y;

   always_comb begin
      cand_x = item.cnt_x | (8'd1 << bit_idx);
      cand_y = item.cnt_y | (8'd1 << bit_idx);
      thr_x  = item.sign_x ? tsn_pkg::ThrNeg[cand_x] : tsn_pkg::ThrPos[cand_x];
      thr_y  = item.sign_y ? tsn_pkg::ThrNeg[cand_y] : tsn_pkg::ThrPos[cand_y];
      rhs_x  = 67'(thr_x) * 67'(item.len_sq);
      rhs_y  = 67'(thr_y) * 67'(item.len_sq);
      lhs_x  = {3'b000, item.csq_x, 48'd0};
      lhs_y  = {3'b000, item.csq_y, 48'd0};
      item_in = item;
      if (lhs_x >= rhs_x) begin
         item_in.cnt_x = cand_x;
      end
      if (lhs_y >= rhs_y) begin
         item_in.cnt_y = cand_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= item_in;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/core/tsn_pack.sv
// Output stage: turns search counts into bytes and arranges them by mode.
// Depends on tsn_pkg.
`default_nettype none
module tsn_pack (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic              in_valid,
   input  wire tsn_pkg::item_type item,
   output logic                   valid_ff,
   output logic [7:0]             r_ff,
   output logic [7:0]             g_ff,
   output logic [7:0]             b_ff,
   output logic [7:0]             a_ff
);
   logic [8:0] sum_x, sum_y;
   logic [7:0] enc_x, enc_y;
   logic [7:0] r_in, g_in, b_in, a_in;

   always_comb begin
      sum_x = item.sign_x ? 9'(tsn_pkg::ByteMid) - 9'(item.cnt_x)
                          : 9'(tsn_pkg::ByteMid) + 9'(item.cnt_x);
      sum_y = item.sign_y ? 9'(tsn_pkg::ByteMid) - 9'(item.cnt_y)
                          : 9'(tsn_pkg::ByteMid) + 9'(item.cnt_y);
      enc_x = sum_x[8] ? 8'hFF : sum_x[7:0];
      enc_y = sum_y[8] ? 8'hFF : sum_y[7:0];
      case (item.mode)
         tsn_pkg::MODE_RGB_OPAQUE: begin
            r_in = item.r; g_in = item.g; b_in = item.b; a_in = 8'hFF;
         end
         tsn_pkg::MODE_RGBA_SWAP: begin
            r_in = item.r; g_in = item.g; b_in = item.b; a_in = item.a;
         end
         tsn_pkg::MODE_NORMAL_AG: begin
            r_in = 8'd0; g_in = enc_y; b_in = 8'd0; a_in = enc_x;
         end
         default: begin
            r_in = enc_x; g_in = enc_y; b_in = 8'd0; a_in = 8'hFF;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         r_ff <= r_in;
         g_ff <= g_in;
         b_ff <= b_in;
         a_ff <= a_in;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/core/texel_swizzle_normal_renorm_unit.sv
// Top level of the texel swizzle and normal renormalize pipeline.
// Depends on tsn_pkg, tsn_front, tsn_search_step and tsn_pack.
//
// Usage:
//   req_* carries one BGRA8 texel per request; rsp_* returns four bytes in
//   RGBA order. csr_mode selects the operation: swap with opaque alpha,
//   plain swap, normal to G/A, or normal to R/G. Write it only while idle.
//   Ten register stages: one entry stage, eight binary search stages (one
//   bit of the encoded byte each, one threshold multiply per component per
//   stage) and one output stage. A texel passes the entry, search and
//   output registers in that order before rsp_valid rises for it.
//   Throughput is one texel per cycle while rsp_ready does not stall it.
//   All stages advance together; when rsp_ready is low with a response
//   waiting, the whole pipeline holds and req_ready drops, so nothing is
//   lost or repeated. An empty output slot lets the pipeline advance.
//   Reset clears all valid bits and sets mode to plain swap; csr_ready is
//   always high.
`default_nettype none
module texel_swizzle_normal_renorm_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [1:0] csr_mode,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_b,
   input  wire logic [7:0] req_in_g,
   input  wire logic [7:0] req_in_r,
   input  wire logic [7:0] req_in_a,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_r,
   output logic [7:0]      rsp_out_g,
   output logic [7:0]      rsp_out_b,
   output logic [7:0]      rsp_out_a
);
   tsn_pkg::mode_type mode_ff;
   logic advance;
   tsn_pkg::item_type item [0:tsn_pkg::SearchSteps];
   logic valid [0:tsn_pkg::SearchSteps];

   assign advance   = rsp_ready | ~rsp_valid;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= tsn_pkg::ModeReset;
      end else if (csr_valid) begin
         mode_ff <= tsn_pkg::mode_type'(csr_mode);
      end
   end

   tsn_front u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_valid),
      .mode     (mode_ff),
      .in_b     (req_in_b),
      .in_g     (req_in_g),
      .in_r     (req_in_r),
      .in_a     (req_in_a),
      .item_ff  (item[0]),
      .valid_ff (valid[0])
   );

   for (genvar i = 0; i < tsn_pkg::SearchSteps; i++) begin : g_step
      tsn_search_step u_step (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .bit_idx  (3'(tsn_pkg::SearchSteps - 1 - i)),
         .in_valid (valid[i]),
         .item     (item[i]),
         .item_ff  (item[i+1]),
         .valid_ff (valid[i+1])
      );
   end

   tsn_pack u_pack (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (valid[tsn_pkg::SearchSteps]),
      .item     (item[tsn_pkg::SearchSteps]),
      .valid_ff (rsp_valid),
      .r_ff     (rsp_out_r),
      .g_ff     (rsp_out_g),
      .b_ff     (rsp_out_b),
      .a_ff     (rsp_out_a)
   );
endmodule
`default_nettype wire

FILE: rtl/core/tsn_checker.sv
// Port-level checks for texel_swizzle_normal_renorm_unit, bound to the top.
// Depends only on the top level's ports.
`default_nettype none
module tsn_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_r,
   input wire logic [7:0] rsp_out_g,
   input wire logic [7:0] rsp_out_b,
   input wire logic [7:0] rsp_out_a
);
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_r)
         && $stable(rsp_out_g) && $stable(rsp_out_b) && $stable(rsp_out_a))
      else $error("stalled response changed");

   a_ready_tracks_out: assert property (@(posedge clock) disable iff (reset)
      req_ready == (rsp_ready || !rsp_valid))
      else $error("request ready does not follow output slot");

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && !req_ready |=> rsp_valid)
      else $error("response dropped while stalled");
endmodule

bind texel_swizzle_normal_renorm_unit tsn_checker u_tsn_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_out_r (rsp_out_r),
   .rsp_out_g (rsp_out_g),
   .rsp_out_b (rsp_out_b),
   .rsp_out_a (rsp_out_a)
);
`default_nettype wire
